@@ rtl/assert_macros.svh @@
// Assertion macros used by the top RTL file of the triage dispatcher.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// An implication checked in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// An implication whose consequence is checked in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/sdt_pkg.sv @@
// Package of the severity triage dispatcher: item types, queue entry type,
// cell and slot control structs, status and kind codes, and parameter defaults.
package sdt_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int SLOT_COUNT_DEF  = 16;
    localparam int T_TYPES         = 16;

    localparam logic [1:0] KIND_ADMIT    = 2'd0;
    localparam logic [1:0] KIND_ADD      = 2'd1;
    localparam logic [1:0] KIND_DISPATCH = 2'd2;
    localparam logic [1:0] KIND_NONE     = 2'd3;

    localparam logic [2:0] ST_ADMITTED   = 3'd0;
    localparam logic [2:0] ST_DUPLICATE  = 3'd1;
    localparam logic [2:0] ST_FULL       = 3'd2;
    localparam logic [2:0] ST_ADDED      = 3'd3;
    localparam logic [2:0] ST_TAKEN      = 3'd4;
    localparam logic [2:0] ST_DISPATCHED = 3'd5;
    localparam logic [2:0] ST_EMPTY      = 3'd6;
    localparam logic [2:0] ST_NOMATCH    = 3'd7;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] request_id;
        logic [3:0]  severity;
        logic [3:0]  needed_type;
        logic [3:0]  slot_number;
        logic [3:0]  slot_type;
        logic        slot_free;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] served_id;
        logic [3:0]  served_severity;
        logic [3:0]  served_slot;
    } t_out_item;

    typedef struct packed {
        logic        valid;
        logic [3:0]  severity;
        logic [15:0] id;
        logic [3:0]  ntype;
    } t_entry;

    typedef struct packed {
        logic   insert;
        logic   remove;
        t_entry entry;
    } t_cell_ctl;

    typedef struct packed {
        logic       add;
        logic [3:0] number;
        logic [3:0] stype;
        logic       sfree;
        logic       take;
        logic [3:0] ttype;
    } t_slot_ctl;

endpackage

@@ rtl/severity_triage_dispatcher.sv @@
// Severity triage dispatcher: a sorted chain of queue cells and a slot table.
// Each item is accepted in S_IDLE, then S_EXEC updates the queue and slots.
// The result is offered in the cycle after the item's update.
// A new item is taken only after the last one has left S_EXEC; the update waits while a result is held.
// Reset (synchronous, active low) empties the queue and the slot table at once.
// Depends on sdt_pkg, sdt_cell, sdt_slots and assert_macros.svh.
`include "assert_macros.svh"

module severity_triage_dispatcher #(
    parameter int QUEUE_DEPTH = sdt_pkg::QUEUE_DEPTH_DEF,
    parameter int SLOT_COUNT  = sdt_pkg::SLOT_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  sdt_pkg::t_in_item  i_in_item,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output sdt_pkg::t_out_item o_out_item,
    input  logic               i_out_stall
);
    import sdt_pkg::*;

    typedef enum logic {S_IDLE, S_EXEC} t_state;

    t_state    r_state;
    t_in_item  r_item;
    logic      r_out_valid;
    t_out_item r_out;

    t_cell_ctl w_ctl;
    t_slot_ctl w_slot_ctl;
    t_entry    w_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_ins;
    logic [QUEUE_DEPTH-1:0] w_found;
    logic [QUEUE_DEPTH-1:0] w_hit;
    logic [QUEUE_DEPTH-1:0] w_dup;
    logic [T_TYPES-1:0]     w_type_free;
    logic                   w_add_ok;
    logic [3:0]             w_take_slot;
    t_entry    w_chosen;
    logic      w_commit;
    logic      w_full;
    logic      w_empty;
    logic      w_any_dup;
    logic      w_any_found;
    t_out_item w_result;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign w_commit    = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);
    assign w_full      = w_entry[QUEUE_DEPTH-1].valid;
    assign w_empty     = !w_entry[0].valid;
    assign w_any_dup   = |w_dup;
    assign w_any_found = w_found[QUEUE_DEPTH-1];

    always_comb begin
        w_ctl.entry.valid    = 1'b1;
        w_ctl.entry.severity = r_item.severity;
        w_ctl.entry.id       = r_item.request_id;
        w_ctl.entry.ntype    = r_item.needed_type;
        w_ctl.insert = w_commit && (r_item.kind == KIND_ADMIT) && !w_any_dup && !w_full;
        w_ctl.remove = w_commit && (r_item.kind == KIND_DISPATCH) && w_any_found;
    end

    // The first eligible cell in service order drives the chosen entry.
    always_comb begin
        w_chosen = '0;
        for (int q = 0; q < QUEUE_DEPTH; q++) begin
            w_chosen = w_chosen | (w_hit[q] ? w_entry[q] : '0);
        end
    end

    for (genvar q = 0; q < QUEUE_DEPTH; q++) begin : g_cell
        t_entry w_prev;
        t_entry w_next;
        logic   w_prev_ins;
        logic   w_found_in;
        if (q == 0) begin : g_head
            assign w_prev     = '0;
            assign w_prev_ins = 1'b0;
            assign w_found_in = 1'b0;
        end else begin : g_body
            assign w_prev     = w_entry[q-1];
            assign w_prev_ins = w_ins[q-1];
            assign w_found_in = w_found[q-1];
        end
        if (q == QUEUE_DEPTH - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_inner
            assign w_next = w_entry[q+1];
        end

        sdt_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_prev      (w_prev),
            .i_prev_ins  (w_prev_ins),
            .i_next      (w_next),
            .i_type_free (w_type_free),
            .i_found     (w_found_in),
            .o_entry     (w_entry[q]),
            .o_ins       (w_ins[q]),
            .o_found     (w_found[q]),
            .o_hit       (w_hit[q]),
            .o_dup       (w_dup[q])
        );
    end

    always_comb begin
        w_slot_ctl.add    = w_commit && (r_item.kind == KIND_ADD);
        w_slot_ctl.number = r_item.slot_number;
        w_slot_ctl.stype  = r_item.slot_type;
        w_slot_ctl.sfree  = r_item.slot_free;
        w_slot_ctl.take   = w_ctl.remove;
        w_slot_ctl.ttype  = w_chosen.ntype;
    end

    sdt_slots #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_slots (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_slot_ctl),
        .o_add_ok    (w_add_ok),
        .o_type_free (w_type_free),
        .o_take_slot (w_take_slot)
    );

    always_comb begin
        w_result = '0;
        unique case (r_item.kind)
            KIND_ADMIT: begin
                if (w_any_dup) begin
                    w_result.status = ST_DUPLICATE;
                end else if (w_full) begin
                    w_result.status = ST_FULL;
                end else begin
                    w_result.status = ST_ADMITTED;
                end
            end
            KIND_ADD: begin
                w_result.status = w_add_ok ? ST_ADDED : ST_TAKEN;
            end
            KIND_DISPATCH: begin
                if (w_empty) begin
                    w_result.status = ST_EMPTY;
                end else if (!w_any_found) begin
                    w_result.status = ST_NOMATCH;
                end else begin
                    w_result.status          = ST_DISPATCHED;
                    w_result.served_id       = w_chosen.id;
                    w_result.served_severity = w_chosen.severity;
                    w_result.served_slot     = w_take_slot;
                end
            end
            default: begin
                w_result = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item  <= i_in_item;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_commit) begin
                        r_state <= S_IDLE;
                        // The unused kind finishes without a result.
                        if (r_item.kind != KIND_NONE) begin
                            r_out <= w_result;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            // A new result may replace one that is taken in the same cycle.
            if (w_commit && (r_item.kind != KIND_NONE)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    `ASSERT_IMPLIES(a_single_winner, i_clk, i_rst_n, w_ctl.remove, $onehot(w_hit))
    `ASSERT_ALWAYS(a_queue_sorted, i_clk, i_rst_n, $onehot0(w_ins & ~{w_ins[QUEUE_DEPTH-2:0], 1'b0}))
    `ASSERT_NEXT(a_insert_fills, i_clk, i_rst_n, w_ctl.insert, w_entry[0].valid)

endmodule

@@ rtl/sdt_cell.sv @@
// One cell of the sorted request queue: holds one entry, inserts by shifting
// right and removes by shifting left. Depends on sdt_pkg.
module sdt_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  sdt_pkg::t_cell_ctl        i_ctl,
    input  sdt_pkg::t_entry           i_prev,
    input  logic                      i_prev_ins,
    input  sdt_pkg::t_entry           i_next,
    input  logic [sdt_pkg::T_TYPES-1:0] i_type_free,
    input  logic                      i_found,
    output sdt_pkg::t_entry           o_entry,
    output logic                      o_ins,
    output logic                      o_found,
    output logic                      o_hit,
    output logic                      o_dup
);
    import sdt_pkg::*;

    t_entry r_entry;
    t_entry n_entry;
    logic   w_first;
    logic   w_elig;

    // The new item is served before this entry.
    assign w_first = (i_ctl.entry.severity > r_entry.severity) ||
                     ((i_ctl.entry.severity == r_entry.severity) &&
                      (i_ctl.entry.id < r_entry.id));
    assign o_ins   = !r_entry.valid || w_first;
    assign o_dup   = r_entry.valid && (i_ctl.entry.severity == r_entry.severity) &&
                     (i_ctl.entry.id == r_entry.id);
    assign w_elig  = r_entry.valid && i_type_free[r_entry.ntype];
    assign o_hit   = w_elig && !i_found;
    assign o_found = i_found || w_elig;
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.remove && o_found) begin
            n_entry = i_next;
        end else if (i_ctl.insert && o_ins) begin
            n_entry = i_prev_ins ? i_prev : i_ctl.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry <= n_entry;
        end
    end

endmodule

@@ rtl/sdt_slots.sv @@
// Resource slot table: add, per-type free summary, lowest free slot lookup
// and marking a slot busy. Depends on sdt_pkg.
module sdt_slots #(
    parameter int SLOT_COUNT = sdt_pkg::SLOT_COUNT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sdt_pkg::t_slot_ctl          i_ctl,
    output logic                        o_add_ok,
    output logic [sdt_pkg::T_TYPES-1:0] o_type_free,
    output logic [3:0]                  o_take_slot
);
    import sdt_pkg::*;

    logic [SLOT_COUNT-1:0] r_valid;
    logic [SLOT_COUNT-1:0] r_avail;
    logic [3:0]            r_kind [SLOT_COUNT];
    logic [T_TYPES-1:0]    r_type_free;
    logic [T_TYPES-1:0]    n_type_free;
    logic [SLOT_COUNT-1:0] w_add_sel;
    logic [SLOT_COUNT-1:0] w_take_sel;

    // A slot number beyond the table matches no slot and is rejected.
    always_comb begin
        o_add_ok = 1'b0;
        for (int s = 0; s < SLOT_COUNT; s++) begin
            w_add_sel[s] = (int'(i_ctl.number) == s);
            if (w_add_sel[s]) begin
                o_add_ok = !r_valid[s];
            end
        end
    end

    always_comb begin
        logic found;
        found       = 1'b0;
        o_take_slot = 4'd0;
        w_take_sel  = '0;
        for (int s = 0; s < SLOT_COUNT; s++) begin
            if (!found && r_valid[s] && r_avail[s] && (r_kind[s] == i_ctl.ttype)) begin
                found         = 1'b1;
                o_take_slot   = 4'(s);
                w_take_sel[s] = 1'b1;
            end
        end
    end

    always_comb begin
        n_type_free = '0;
        for (int t = 0; t < T_TYPES; t++) begin
            for (int s = 0; s < SLOT_COUNT; s++) begin
                if (r_valid[s] && r_avail[s] && (int'(r_kind[s]) == t)) begin
                    n_type_free[t] = 1'b1;
                end
            end
        end
    end

    assign o_type_free = r_type_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_avail     <= '0;
            r_type_free <= '0;
        end else begin
            r_type_free <= n_type_free;
            for (int s = 0; s < SLOT_COUNT; s++) begin
                if (i_ctl.add && o_add_ok && w_add_sel[s]) begin
                    r_valid[s] <= 1'b1;
                    r_avail[s] <= i_ctl.sfree;
                end else if (i_ctl.take && w_take_sel[s]) begin
                    r_avail[s] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < SLOT_COUNT; s++) begin
            if (i_ctl.add && o_add_ok && w_add_sel[s]) begin
                r_kind[s] <= i_ctl.stype;
            end
        end
    end

endmodule

@@ bench/severity_triage_dispatcher_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench of severity_triage_dispatcher: directed and random items,
// checked against a behavioral copy of the request queue and the slot table.
// Depends on sdt_pkg and the dispatcher RTL.
module severity_triage_dispatcher_test;
    import sdt_pkg::*;

    localparam int         DEPTH        = QUEUE_DEPTH_DEF;
    localparam int         SLOTS        = SLOT_COUNT_DEF;
    localparam int         RANDOM_ITEMS = 720;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         DRAIN_CYCLES = 20;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    t_in_item   i_in_item   = '0;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_item  o_out_item;
    logic       i_out_stall = 1'b0;

    // Behavioral copy of the queue and the slot table.
    bit          req_live[DEPTH];
    logic [3:0]  req_sev[DEPTH];
    logic [15:0] req_id[DEPTH];
    logic [3:0]  req_type[DEPTH];
    bit          res_present[SLOTS];
    logic [3:0]  res_type[SLOTS];
    bit          res_free[SLOTS];

    t_out_item pending_outcomes[$];
    int        errors         = 0;
    bit        sender_idles   = 1'b1;
    bit        receiver_idles = 1'b1;
    int        hold_left      = 0;

    severity_triage_dispatcher u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

    always #10 i_clk = ~i_clk;

    // Lowest present, free resource of the given type, or -1.
    function automatic int free_resource(logic [3:0] rtype);
        for (int s = 0; s < SLOTS; s++)
            if (res_present[s] && res_free[s] && res_type[s] == rtype)
                return s;
        return -1;
    endfunction

    function automatic int queued_count();
        int n;
        n = 0;
        for (int q = 0; q < DEPTH; q++)
            n += req_live[q];
        return n;
    endfunction

    // Updates the copy for one accepted item and queues the outcome it gives.
    function automatic void triage_outcome(t_in_item it);
        t_out_item r;
        int        spare;
        int        pick;
        int        pick_slot;
        int        s;
        bit        any;
        r = '0;
        spare = -1;
        pick = -1;
        pick_slot = -1;
        any = 1'b0;
        case (it.kind)
            KIND_ADMIT: begin
                r.status = ST_ADMITTED;
                for (int q = 0; q < DEPTH; q++) begin
                    if (req_live[q]) begin
                        if (req_id[q] == it.request_id && req_sev[q] == it.severity)
                            r.status = ST_DUPLICATE;
                    end else if (spare < 0) begin
                        spare = q;
                    end
                end
                if (r.status == ST_ADMITTED) begin
                    if (spare < 0) begin
                        r.status = ST_FULL;
                    end else begin
                        req_live[spare] = 1'b1;
                        req_id[spare]   = it.request_id;
                        req_sev[spare]  = it.severity;
                        req_type[spare] = it.needed_type;
                    end
                end
                pending_outcomes = {pending_outcomes, r};
            end
            KIND_ADD: begin
                if (res_present[it.slot_number]) begin
                    r.status = ST_TAKEN;
                end else begin
                    r.status = ST_ADDED;
                    res_present[it.slot_number] = 1'b1;
                    res_type[it.slot_number]    = it.slot_type;
                    res_free[it.slot_number]    = it.slot_free;
                end
                pending_outcomes = {pending_outcomes, r};
            end
            KIND_DISPATCH: begin
                for (int q = 0; q < DEPTH; q++) begin
                    if (req_live[q]) begin
                        any = 1'b1;
                        s = free_resource(req_type[q]);
                        if (s >= 0 && (pick < 0 || req_sev[q] > req_sev[pick] ||
                                (req_sev[q] == req_sev[pick] && req_id[q] < req_id[pick]))) begin
                            pick = q;
                            pick_slot = s;
                        end
                    end
                end
                if (!any) begin
                    r.status = ST_EMPTY;
                end else if (pick < 0) begin
                    r.status = ST_NOMATCH;
                end else begin
                    r.status          = ST_DISPATCHED;
                    r.served_id       = req_id[pick];
                    r.served_severity = req_sev[pick];
                    r.served_slot     = 4'(pick_slot);
                    req_live[pick]      = 1'b0;
                    res_free[pick_slot] = 1'b0;
                end
                pending_outcomes = {pending_outcomes, r};
            end
            default: begin
                // The unused kind leaves everything alone and returns nothing.
            end
        endcase
    endfunction

    // Fields that the kind does not use carry random values.
    function automatic t_in_item noise_item(logic [1:0] kind);
        t_in_item it;
        it.kind        = kind;
        it.request_id  = 16'($urandom_range(65535));
        it.severity    = 4'($urandom_range(15));
        it.needed_type = 4'($urandom_range(15));
        it.slot_number = 4'($urandom_range(15));
        it.slot_type   = 4'($urandom_range(15));
        it.slot_free   = 1'($urandom_range(1));
        return it;
    endfunction

    function automatic t_in_item admit_item(logic [15:0] id, logic [3:0] sev, logic [3:0] ntype);
        t_in_item it;
        it = noise_item(KIND_ADMIT);
        it.request_id  = id;
        it.severity    = sev;
        it.needed_type = ntype;
        return it;
    endfunction

    function automatic t_in_item add_item(logic [3:0] slot, logic [3:0] stype, logic sfree);
        t_in_item it;
        it = noise_item(KIND_ADD);
        it.slot_number = slot;
        it.slot_type   = stype;
        it.slot_free   = sfree;
        return it;
    endfunction

    // Types are mostly kept small so that requests and resources meet.
    function automatic logic [3:0] pick_type();
        return ($urandom_range(7) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(3));
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        int       r;
        int       e;
        r = $urandom_range(99);
        if (r < 40) begin
            it = admit_item(($urandom_range(3) == 0) ? 16'($urandom_range(7))
                                                      : 16'($urandom_range(65535)),
                            4'($urandom_range(15)), pick_type());
            // Some admits repeat a pair that is already queued.
            e = $urandom_range(DEPTH - 1);
            if (req_live[e] && $urandom_range(4) == 0) begin
                it.request_id = req_id[e];
                it.severity   = req_sev[e];
            end
        end else if (r < 48) begin
            it = add_item(4'($urandom_range(15)), pick_type(), $urandom_range(9) != 0);
        end else if (r < 95) begin
            it = noise_item(KIND_DISPATCH);
        end else begin
            it = noise_item(KIND_NONE);
        end
        return it;
    endfunction

    // Offers one item and returns once it has been accepted.
    task automatic send_item(input t_in_item it);
        while (sender_idles && $urandom_range(99) < 14) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        triage_outcome(it);
    endtask

    task automatic test_directed();
        send_item(noise_item(KIND_DISPATCH));             // empty queue
        send_item(noise_item(KIND_NONE));                 // ignored kind
        send_item(add_item(4'd14, 4'd15, 1'b0));          // resource starts busy
        send_item(add_item(4'd14, 4'd3, 1'b1));           // slot already used
        send_item(admit_item(16'hFFFF, 4'd15, 4'd15));
        send_item(admit_item(16'hFFFF, 4'd15, 4'd0));     // same pair, other type
        send_item(noise_item(KIND_DISPATCH));             // no eligible request
        send_item(add_item(4'd0, 4'd0, 1'b1));
        send_item(admit_item(16'h0000, 4'd0, 4'd0));
        send_item(admit_item(16'h0005, 4'd0, 4'd0));
        send_item(admit_item(16'h0000, 4'd15, 4'd0));     // same id, new severity
        send_item(admit_item(16'h0003, 4'd15, 4'd0));
        send_item(noise_item(KIND_DISPATCH));
        send_item(noise_item(KIND_DISPATCH));
        send_item(add_item(4'd1, 4'd0, 1'b1));
        send_item(add_item(4'd2, 4'd0, 1'b1));
        send_item(noise_item(KIND_DISPATCH));
        send_item(noise_item(KIND_DISPATCH));             // equal severity, lower id
        send_item(add_item(4'd15, 4'd15, 1'b1));
        send_item(noise_item(KIND_DISPATCH));
        send_item(noise_item(KIND_DISPATCH));
    endtask

    task automatic test_random_mix();
        for (int n = 0; n < RANDOM_ITEMS; n++)
            send_item(random_item());
    endtask

    task automatic test_back_to_back();
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        for (int n = 0; n < 100; n++)
            send_item(random_item());
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
    endtask

    // The receiver holds off while items keep coming, so the block backs up.
    task automatic test_output_hold();
        hold_left = HOLD_CYCLES;
        for (int n = 0; n < 40; n++)
            send_item(random_item());
    endtask

    task automatic test_queue_full();
        int e;
        while (queued_count() < DEPTH)
            send_item(admit_item(16'($urandom_range(65535)), 4'($urandom_range(15)),
                                 pick_type()));
        send_item(admit_item(16'($urandom_range(65535)), 4'($urandom_range(15)), pick_type()));
        // A repeated pair is reported as such even when the queue is full.
        e = $urandom_range(DEPTH - 1);
        send_item(admit_item(req_id[e], req_sev[e], pick_type()));
    endtask

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            i_out_stall <= receiver_idles && ($urandom_range(99) < 14);
        end
    end

    function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_outcomes.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p",
                         $time, o_out_item);
                errors++;
            end else begin
                want = pending_outcomes.pop_front();
                compare_field("status", 16'(want.status), 16'(o_out_item.status));
                compare_field("served_id", want.served_id, o_out_item.served_id);
                compare_field("served_severity", 16'(want.served_severity),
                              16'(o_out_item.served_severity));
                compare_field("served_slot", 16'(want.served_slot),
                              16'(o_out_item.served_slot));
            end
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_mix();
        test_back_to_back();
        test_output_hold();
        test_queue_full();
        i_in_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, pending_outcomes.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
